@@ src/assert_macros.svh @@
// Assertion macros for the RTL files; config_text_lexer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALL(lbl, prop, msg)
`endif

`endif

@@ src/ctl_pkg.sv @@
package ctl_pkg;

  // Lexer mode held between text bytes.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_CHAR,
    MODE_COMMENT
  } mode_t;

  // Token kind codes.
  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_NUMBER = 4'd1;
  localparam logic [3:0] KIND_EOF    = 4'd2;
  localparam logic [3:0] KIND_BAD    = 4'd3;
  localparam logic [3:0] KIND_STRING = 4'd4;
  localparam logic [3:0] KIND_CHAR   = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_EQ     = 4'd8;
  localparam logic [3:0] KIND_SEMI   = 4'd9;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // One result item.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] tbyte;
    logic       present;
    logic       done;
    logic       last;
  } result_t;

  // Decoder outcome for one text byte.
  typedef struct packed {
    mode_t      mode_next;
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } decode_t;

endpackage

@@ src/ctl_decode.sv @@
module ctl_decode import ctl_pkg::*; (
  input  mode_t       mode,
  input  logic [7:0]  text_byte,
  output decode_t     dec
);

  typedef struct packed {
    mode_t   mode;
    logic    has;
    result_t res;
  } fresh_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic result_t mk(input logic [3:0] kind, input logic [7:0] b,
                                 input logic present, input logic done);
    result_t r;
    r.kind    = kind;
    r.tbyte   = present ? b : 8'h00;
    r.present = present;
    r.done    = done;
    r.last    = 1'b0;
    return r;
  endfunction

  // Lex one byte as if the lexer were idle.
  function automatic fresh_t lex_fresh(input logic [7:0] b);
    fresh_t f;
    f.mode = MODE_IDLE;
    f.has  = 1'b1;
    f.res  = mk(KIND_BAD, b, 1'b0, 1'b1);
    if (is_letter(b)) begin
      f.mode = MODE_IDENT;
      f.res  = mk(KIND_IDENT, b, 1'b1, 1'b0);
    end else if (is_digit(b)) begin
      f.mode = MODE_NUMBER;
      f.res  = mk(KIND_NUMBER, b, 1'b1, 1'b0);
    end else if (b == CH_NUL) begin
      f.res = mk(KIND_EOF, b, 1'b0, 1'b1);
    end else if (is_space(b)) begin
      f.has = 1'b0;
    end else if (b == CH_HASH) begin
      f.has  = 1'b0;
      f.mode = MODE_COMMENT;
    end else if (b == CH_DQUOTE) begin
      f.has  = 1'b0;
      f.mode = MODE_STRING;
    end else if (b == CH_SQUOTE) begin
      f.has  = 1'b0;
      f.mode = MODE_CHAR;
    end else if (b == CH_LBRACE) begin
      f.res = mk(KIND_LBRACE, b, 1'b1, 1'b1);
    end else if (b == CH_RBRACE) begin
      f.res = mk(KIND_RBRACE, b, 1'b1, 1'b1);
    end else if (b == CH_EQ) begin
      f.res = mk(KIND_EQ, b, 1'b1, 1'b1);
    end else if (b == CH_SEMI) begin
      f.res = mk(KIND_SEMI, b, 1'b1, 1'b1);
    end
    return f;
  endfunction

  fresh_t     fresh;
  logic       is_ident;
  logic       is_str;
  logic       run_match;
  logic [3:0] run_kind;
  logic [3:0] lit_kind;
  logic [7:0] lit_quote;

  // Next mode and up to two results for the incoming byte.
  always_comb begin
    fresh     = lex_fresh(text_byte);
    is_ident  = (mode == MODE_IDENT);
    is_str    = (mode == MODE_STRING);
    run_match = is_ident ? is_letter(text_byte) : is_digit(text_byte);
    run_kind  = is_ident ? KIND_IDENT : KIND_NUMBER;
    lit_kind  = is_str ? KIND_STRING : KIND_CHAR;
    lit_quote = is_str ? CH_DQUOTE : CH_SQUOTE;

    dec.mode_next = mode;
    dec.count     = 2'd0;
    dec.r0        = '0;
    dec.r1        = '0;

    case (mode)
      MODE_IDENT, MODE_NUMBER: begin
        if (run_match) begin
          dec.r0    = mk(run_kind, text_byte, 1'b1, 1'b0);
          dec.count = 2'd1;
        end else begin
          // The run ends; the ending byte is lexed afresh.
          dec.r0        = mk(run_kind, text_byte, 1'b0, 1'b1);
          dec.r1        = fresh.res;
          dec.count     = fresh.has ? 2'd2 : 2'd1;
          dec.mode_next = fresh.mode;
        end
      end
      MODE_STRING, MODE_CHAR: begin
        if (text_byte == lit_quote) begin
          dec.r0        = mk(lit_kind, text_byte, 1'b0, 1'b1);
          dec.count     = 2'd1;
          dec.mode_next = MODE_IDLE;
        end else if (text_byte == CH_NUL) begin
          // End of text closes the literal and then reports EOF.
          dec.r0        = mk(lit_kind, text_byte, 1'b0, 1'b1);
          dec.r1        = mk(KIND_EOF, text_byte, 1'b0, 1'b1);
          dec.count     = 2'd2;
          dec.mode_next = MODE_IDLE;
        end else begin
          dec.r0    = mk(lit_kind, text_byte, 1'b1, 1'b0);
          dec.count = 2'd1;
        end
      end
      MODE_COMMENT: begin
        if (text_byte == CH_NL) begin
          dec.mode_next = MODE_IDLE;
        end else if (text_byte == CH_NUL) begin
          dec.r0        = mk(KIND_EOF, text_byte, 1'b0, 1'b1);
          dec.count     = 2'd1;
          dec.mode_next = MODE_IDLE;
        end
      end
      default: begin
        dec.r0        = fresh.res;
        dec.count     = {1'b0, fresh.has};
        dec.mode_next = fresh.mode;
      end
    endcase

    // Mark the final result of this byte.
    if (dec.count == 2'd2) begin
      dec.r1.last = 1'b1;
    end else begin
      dec.r0.last = 1'b1;
    end
  end

endmodule

@@ src/config_text_lexer.sv @@
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid / in_stall | text_byte
// output   | out_valid/out_stall | token_kind, token_byte, byte_present, token_done,
//          |                     | last
//
// A text byte is decoded in the cycle it is accepted; its results enter a
// four-entry queue and the head appears on the output in the next cycle.
// One byte per cycle is accepted while in_stall is low, and results drain one per
// cycle while out_stall is low; a byte that gives two results fills two queue entries.
// in_stall is high during reset and when the queue has fewer than two free entries.
// Synchronous reset empties the queue and returns the lexer to idle.
module config_text_lexer import ctl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] token_kind,
  output logic [7:0] token_byte,
  output logic       byte_present,
  output logic       token_done,
  output logic       last
);

  `include "assert_macros.svh"

  mode_t                 lexer_mode;
  decode_t               dec;
  result_t               fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic [1:0]            wr_n;
  logic                  in_acc;
  logic                  out_acc;
  result_t               head;

  // Byte decode from the current mode.
  ctl_decode u_decode (
    .mode      (lexer_mode),
    .text_byte (text_byte),
    .dec       (dec)
  );

  assign in_stall  = rst || (count > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && !out_stall;
  assign wr_n      = in_acc ? dec.count : 2'd0;

  // Occupancy after this cycle's writes and read.
  always_comb begin
    count_next = count + FIFO_CNT_W'(wr_n) - FIFO_CNT_W'(out_acc);
  end

  // Mode register and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode <= MODE_IDLE;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (in_acc) begin
        lexer_mode <= dec.mode_next;
      end
      wr_ptr <= wr_ptr + FIFO_PTR_W'(wr_n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(out_acc);
      count  <= count_next;
    end
  end

  // Result storage: the second result goes one entry past the first.
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      fifo[wr_ptr] <= dec.r0;
    end
    if (wr_n == 2'd2) begin
      fifo[wr_ptr + FIFO_PTR_W'(1)] <= dec.r1;
    end
  end

  // Head of the queue drives the output fields.
  assign head         = fifo[rd_ptr];
  assign token_kind   = head.kind;
  assign token_byte   = head.tbyte;
  assign byte_present = head.present;
  assign token_done   = head.done;
  assign last         = head.last;

  `ASSERT_CLK(a_count_bound, count <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
  `ASSERT_CLK(a_second_waits, (out_valid && !last) |-> (count >= FIFO_CNT_W'(2)),
              "result of a two-result item lost")
  `ASSERT_CLK(a_no_text_eof, (out_valid && byte_present) |->
              (token_kind != KIND_EOF && token_kind != KIND_BAD), "EOF or BAD carries text")
  `ASSERT_CLK(a_reset_empty, $past(rst) |-> (count == '0 && lexer_mode == MODE_IDLE),
              "reset left state behind")

endmodule

@@ verif/tb_config_text_lexer.sv @@
module tb_config_text_lexer;
  import ctl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the lexer mode and holds the token results still to come out.
  class lexer_scoreboard;
    mode_t   mode;
    result_t staged[$];
    result_t expected_q[$];
    int      errors;
    int      checked;

    function new();
      mode = MODE_IDLE;
      errors = 0;
      checked = 0;
    endfunction

    function bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_space(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function void stage(logic [3:0] kind, logic [7:0] b, logic present, logic done);
      result_t r;
      r.kind = kind;
      r.tbyte = present ? b : 8'h00;
      r.present = present;
      r.done = done;
      r.last = 1'b0;
      staged.push_back(r);
    endfunction

    // Lexes one byte as the start of a new token.
    function void lex_from_idle(logic [7:0] b);
      mode = MODE_IDLE;
      if (is_letter(b)) begin
        mode = MODE_IDENT;
        stage(KIND_IDENT, b, 1'b1, 1'b0);
      end else if (is_digit(b)) begin
        mode = MODE_NUMBER;
        stage(KIND_NUMBER, b, 1'b1, 1'b0);
      end else if (b == CH_NUL) begin
        stage(KIND_EOF, b, 1'b0, 1'b1);
      end else if (is_space(b)) begin
        mode = MODE_IDLE;
      end else if (b == CH_HASH) begin
        mode = MODE_COMMENT;
      end else if (b == CH_DQUOTE) begin
        mode = MODE_STRING;
      end else if (b == CH_SQUOTE) begin
        mode = MODE_CHAR;
      end else if (b == CH_LBRACE) begin
        stage(KIND_LBRACE, b, 1'b1, 1'b1);
      end else if (b == CH_RBRACE) begin
        stage(KIND_RBRACE, b, 1'b1, 1'b1);
      end else if (b == CH_EQ) begin
        stage(KIND_EQ, b, 1'b1, 1'b1);
      end else if (b == CH_SEMI) begin
        stage(KIND_SEMI, b, 1'b1, 1'b1);
      end else begin
        stage(KIND_BAD, b, 1'b0, 1'b1);
      end
    endfunction

    // Works out the results of one accepted text byte.
    function void note_text(logic [7:0] b);
      logic [3:0] kind;
      logic [7:0] quote;
      bit         same;
      result_t    r;
      staged.delete();
      case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          kind = (mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          same = (mode == MODE_IDENT) ? is_letter(b) : is_digit(b);
          if (same) begin
            stage(kind, b, 1'b1, 1'b0);
          end else begin
            stage(kind, b, 1'b0, 1'b1);
            lex_from_idle(b);
          end
        end
        MODE_STRING, MODE_CHAR: begin
          kind = (mode == MODE_STRING) ? KIND_STRING : KIND_CHAR;
          quote = (mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
          if (b == quote) begin
            stage(kind, b, 1'b0, 1'b1);
            mode = MODE_IDLE;
          end else if (b == CH_NUL) begin
            stage(kind, b, 1'b0, 1'b1);
            stage(KIND_EOF, b, 1'b0, 1'b1);
            mode = MODE_IDLE;
          end else begin
            stage(kind, b, 1'b1, 1'b0);
          end
        end
        MODE_COMMENT: begin
          if (b == CH_NL) begin
            mode = MODE_IDLE;
          end else if (b == CH_NUL) begin
            stage(KIND_EOF, b, 1'b0, 1'b1);
            mode = MODE_IDLE;
          end
        end
        default: begin
          lex_from_idle(b);
        end
      endcase
      if (staged.size() > 0) begin
        r = staged.pop_back();
        r.last = 1'b1;
        staged.push_back(r);
      end
      foreach (staged[i]) expected_q.push_back(staged[i]);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%h present=%b done=%b last=%b",
                 $time, got.kind, got.tbyte, got.present, got.done, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.kind !== want.kind) begin
        $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.tbyte !== want.tbyte) begin
        $display("%0t: token_byte expected %h actual %h", $time, want.tbyte, got.tbyte);
        errors++;
      end
      if (got.present !== want.present) begin
        $display("%0t: byte_present expected %b actual %b", $time, want.present, got.present);
        errors++;
      end
      if (got.done !== want.done) begin
        $display("%0t: token_done expected %b actual %b", $time, want.done, got.done);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] token_kind;
  logic [7:0] token_byte;
  logic       byte_present;
  logic       token_done;
  logic       last;

  lexer_scoreboard sb = new();
  int  send_idle = 0;
  int  recv_idle = 0;
  int  bytes_sent = 0;
  logic hold_pending = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  config_text_lexer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_byte(token_byte),
    .byte_present(byte_present),
    .token_done(token_done),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fixed time limit for the whole run.
  initial begin
    #2000000;
    $display("tb_config_text_lexer NOT OK");
    $finish;
  end

  // Output side: checks accepted results, stalls at random or for a long hold-off.
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = token_kind;
      got.tbyte = token_byte;
      got.present = byte_present;
      got.done = token_done;
      got.last = last;
      sb.check_result(got);
    end
    if (hold_pending && !hold_taken) begin
      hold_left = 80;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Offers one text byte, with random idle cycles first, until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_text(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == stop || b == CH_NUL);
    return b;
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'(8'h61 + $urandom_range(25));
    return 8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_space();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  // A string or char literal, usually closed, sometimes cut off by end of text.
  task automatic send_quoted(input logic [7:0] quote);
    int n;
    n = $urandom_range(5);
    send_byte(quote);
    repeat (n) send_byte(byte_other_than(quote));
    send_byte(($urandom_range(9) == 0) ? CH_NUL : quote);
  endtask

  // One random piece of text: mostly well-formed tokens, some noise.
  task automatic send_random_piece();
    int pick;
    int n;
    pick = $urandom_range(99);
    n = $urandom_range(1, 6);
    if (pick < 20) begin
      repeat (n) send_byte(rand_letter());
    end else if (pick < 35) begin
      repeat (n) send_byte(8'(8'h30 + $urandom_range(9)));
    end else if (pick < 48) begin
      send_quoted(CH_DQUOTE);
    end else if (pick < 56) begin
      send_quoted(CH_SQUOTE);
    end else if (pick < 64) begin
      send_byte(CH_HASH);
      repeat (n - 1) send_byte(byte_other_than(CH_NL));
      send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_NL);
    end else if (pick < 78) begin
      case ($urandom_range(3))
        0: send_byte(CH_LBRACE);
        1: send_byte(CH_RBRACE);
        2: send_byte(CH_EQ);
        default: send_byte(CH_SEMI);
      endcase
    end else if (pick < 88) begin
      send_byte(rand_space());
    end else if (pick < 95) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 97) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(8'($urandom_range(128, 255)));
    end
  endtask

  initial begin
    logic [7:0] directed [26];
    int wait_cycles;

    directed = '{
      CH_LBRACE, CH_RBRACE, CH_EQ, CH_SEMI, 8'h80, 8'hff, CH_NUL, CH_NUL,
      "a", "b", CH_EQ, "9", "z", 8'h09, CH_DQUOTE, CH_DQUOTE,
      CH_SQUOTE, "x", CH_NUL, CH_DQUOTE, CH_NUL, CH_HASH, "c", CH_NL,
      CH_HASH, CH_NUL
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed text: single-byte tokens, bad bytes, end of text, literals, comments and token endings.
    foreach (directed[i]) send_byte(directed[i]);

    // Random text under three idling mixes.
    send_idle = 13;
    recv_idle = 87;
    while (bytes_sent < 160) send_random_piece();
    send_idle = 87;
    recv_idle = 13;
    while (bytes_sent < 295) send_random_piece();
    send_idle = 0;
    recv_idle = 0;
    hold_pending <= 1'b1;
    while (bytes_sent < 430) send_random_piece();
    in_valid <= 1'b0;

    // Drain whatever is still expected, then a few extra cycles.
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d text bytes and checked %0d token results", bytes_sent, sb.checked);
    $display("across three idling mixes and a long output hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_config_text_lexer OK");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d expected results never came", $time, sb.pending());
      $display("tb_config_text_lexer NOT OK");
    end
    $finish;
  end

endmodule

@@ config_text_lexer.f @@
+incdir+src
src/ctl_pkg.sv
src/ctl_decode.sv
src/config_text_lexer.sv
verif/tb_config_text_lexer.sv
